[hdl/edge_degree_boundary_finder_defines.svh]
// Assertion macros for the module that checks its own logic.
`ifndef EDGE_DEGREE_BOUNDARY_FINDER_DEFINES_SVH
`define EDGE_DEGREE_BOUNDARY_FINDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EDB_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("edge_degree_boundary_finder: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EDB_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("edge_degree_boundary_finder: assertion failed");

`endif

[hdl/edb_pkg.sv]
package edb_pkg;

  typedef enum logic [1:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_FIRST,
    SEQ_SECOND
  } seq_state_t;

  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SKIP  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_LIMIT = 2'd1;

  localparam int VC_W   = 11;
  localparam int DEG_W  = 4;
  localparam int END_W  = 11;
  localparam int VIDX_W = 10;

  localparam logic [DEG_W-1:0] DEG_MAX      = 4'd15;
  localparam logic [VC_W-1:0]  VC_RESET     = 11'd1024;
  localparam logic [DEG_W-1:0] LIMIT_RESET  = 4'd3;
  localparam logic [END_W-1:0] END_MISSING  = 11'h7FF;

  typedef struct packed {
    logic [VC_W-1:0]  vertex_count;
    logic [DEG_W-1:0] degree_limit;
  } cfg_t;

  typedef struct packed {
    logic [VIDX_W-1:0] vertex_index;
    logic [DEG_W-1:0]  degree;
    logic              is_boundary;
    logic [1:0]        status;
  } result_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } seq_stat_t;

  function automatic logic [DEG_W-1:0] sat_add(input logic [DEG_W-1:0] cnt,
                                               input logic [1:0] inc);
    logic [DEG_W:0] sum;
    sum = {1'b0, cnt} + {3'b000, inc};
    return (sum > {1'b0, DEG_MAX}) ? DEG_MAX : sum[DEG_W-1:0];
  endfunction

endpackage

[hdl/edb_counter_mem.sv]
module edb_counter_mem
  import edb_pkg::*;
#(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DEG_W-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DEG_W-1:0]  rdata
);

  logic [DEG_W-1:0]  mem [DEPTH];
  logic [DEG_W-1:0]  rdata_r;
  logic [ADDR_W-1:0] raddr_r;
  logic              fwd_en_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  logic [DEG_W-1:0]  fwd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r    <= mem[raddr];
    raddr_r    <= raddr;
    fwd_addr_r <= waddr;
    fwd_data_r <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_en_r <= 1'b0;
    end else begin
      fwd_en_r <= we;
    end
  end

  // A read issued in the same cycle as a write to that entry sees the new value.
  assign rdata = (fwd_en_r && (fwd_addr_r == raddr_r)) ? fwd_data_r : rdata_r;

endmodule

[hdl/edb_result_fifo.sv]
module edb_result_fifo
  import edb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    out_valid,
  output result_t out_data,
  output logic    full
);

  result_t    slot_r [2];
  logic       rd_ptr_r;
  logic       wr_ptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_valid = (count_r != 2'd0);
  assign out_data  = slot_r[rd_ptr_r];
  assign full      = (count_r == 2'd2);

endmodule

[hdl/edb_seq.sv]
module edb_seq
  import edb_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int ADDR_W       = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [END_W-1:0]  in_end_a,
  input  logic [END_W-1:0]  in_end_b,
  input  logic              pop,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [DEG_W-1:0]  mem_wdata,
  output logic [ADDR_W-1:0] mem_raddr,
  input  logic [DEG_W-1:0]  mem_rdata,
  output logic              res_push,
  output result_t           res_data,
  output seq_stat_t         stat
);

  localparam logic [16:0]       MAX_V    = 17'(MAX_VERTICES);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_VERTICES - 1);

  seq_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [1:0]        occ_r, occ_nxt;

  logic              op_r;
  logic [VIDX_W-1:0] a_idx_r;
  logic [ADDR_W-1:0] addr_a_r;
  logic [ADDR_W-1:0] addr_b_r;
  logic [1:0]        inc_r;
  logic              two_r;
  logic              active_r;
  logic [1:0]        status_r;

  logic [VIDX_W-1:0] a_idx, b_idx;
  logic              a_miss, b_miss, a_ok, b_ok;
  logic [1:0]        status_in;
  logic              finishing, can_take, accept, qry;

  assign a_idx  = in_end_a[VIDX_W-1:0];
  assign b_idx  = in_end_b[VIDX_W-1:0];
  assign a_miss = (in_end_a == END_MISSING);
  assign b_miss = (in_end_b == END_MISSING);
  assign a_ok   = !in_end_a[END_W-1] && ({1'b0, a_idx} < cfg.vertex_count) &&
                  ({7'b0, a_idx} < MAX_V);
  assign b_ok   = !in_end_b[END_W-1] && ({1'b0, b_idx} < cfg.vertex_count) &&
                  ({7'b0, b_idx} < MAX_V);

  always_comb begin
    if (in_op == OP_EDGE) begin
      if (a_miss || b_miss) begin
        status_in = STATUS_SKIP;
      end else if (!a_ok || !b_ok) begin
        status_in = STATUS_RANGE;
      end else begin
        status_in = STATUS_OK;
      end
    end else begin
      status_in = a_ok ? STATUS_OK : STATUS_RANGE;
    end
  end

  assign finishing = ((state_r == SEQ_FIRST) && !two_r) || (state_r == SEQ_SECOND);
  assign can_take  = ((state_r == SEQ_IDLE) || finishing) && ((occ_r != 2'd2) || pop);
  assign in_stall  = !can_take;
  assign accept    = in_valid && can_take;
  assign occ_nxt   = occ_r + {1'b0, accept} - {1'b0, pop};
  assign qry       = (op_r == OP_QUERY) && active_r;

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = addr_a_r;
    mem_wdata = '0;
    mem_raddr = ADDR_W'(a_idx);
    case (state_r)
      SEQ_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = SEQ_IDLE;
        end
      end
      SEQ_IDLE: begin
        if (accept) begin
          state_nxt = SEQ_FIRST;
        end
      end
      SEQ_FIRST: begin
        mem_we    = active_r;
        mem_wdata = (op_r == OP_QUERY) ? '0 : sat_add(mem_rdata, inc_r);
        if (two_r) begin
          mem_raddr = addr_b_r;
          state_nxt = SEQ_SECOND;
        end else begin
          state_nxt = accept ? SEQ_FIRST : SEQ_IDLE;
        end
      end
      SEQ_SECOND: begin
        mem_we    = 1'b1;
        mem_waddr = addr_b_r;
        mem_wdata = sat_add(mem_rdata, 2'd1);
        state_nxt = accept ? SEQ_FIRST : SEQ_IDLE;
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  assign res_push              = finishing;
  assign res_data.vertex_index = qry ? a_idx_r : '0;
  assign res_data.degree       = qry ? mem_rdata : '0;
  assign res_data.is_boundary  = qry && (mem_rdata < cfg.degree_limit);
  assign res_data.status       = status_r;

  assign stat.clearing = (state_r == SEQ_CLEAR);
  assign stat.busy     = (state_r == SEQ_FIRST) || (state_r == SEQ_SECOND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= SEQ_CLEAR;
      clr_cnt_r <= '0;
      occ_r     <= 2'd0;
      active_r  <= 1'b0;
      two_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (state_r == SEQ_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (accept) begin
        active_r <= (status_in == STATUS_OK);
        two_r    <= (in_op == OP_EDGE) && (status_in == STATUS_OK) && (a_idx != b_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      a_idx_r  <= a_idx;
      addr_a_r <= ADDR_W'(a_idx);
      addr_b_r <= ADDR_W'(b_idx);
      inc_r    <= (a_idx == b_idx) ? 2'd2 : 2'd1;
      status_r <= status_in;
    end
  end

endmodule

[hdl/edge_degree_boundary_finder.sv]
// Vertex degree counter with a boundary threshold.
// Input requests carry an op bit and two signed 11-bit endpoints. An add-edge
// request increments both endpoint counters (a self-loop adds two), saturating
// at 15; a query request returns the vertex degree and a boundary flag and
// clears that counter. Exactly one result request is produced per input.
// The configuration port writes vertex_count (index 0) and degree_limit
// (index 1) and is always ready; the user must see that it is written only
// while the block is idle, which the block does not enforce. A query, a
// self-loop, a skipped edge or an out-of-range edge passes through SEQ_FIRST
// only, so such requests can follow back to back; an edge with two distinct
// endpoints passes through SEQ_FIRST and SEQ_SECOND, one read-modify-write
// per cycle on the counter memory, and in_stall is high during SEQ_FIRST.
// At most two requests are held between input and output, in flight or
// waiting in the two result slots; while both are held and no result leaves,
// in_stall is high. A stalled result and its payload stay unchanged until
// the receiver takes it. After reset the counter memory is cleared one entry
// per cycle; in_stall is high throughout, configuration writes are still
// taken and the registers return to 1024 vertices and a limit of 3.
`include "edge_degree_boundary_finder_defines.svh"

module edge_degree_boundary_finder
  import edb_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic signed [END_W-1:0] in_end_a,
  input  logic signed [END_W-1:0] in_end_b,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VIDX_W-1:0]     out_vertex_index,
  output logic [DEG_W-1:0]      out_degree,
  output logic                  out_is_boundary,
  output logic [1:0]            out_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [VC_W-1:0]       cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_VERTICES);

  cfg_t              cfg_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DEG_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DEG_W-1:0]  mem_rdata;
  logic              res_push;
  result_t           res_data;
  result_t           out_data;
  seq_stat_t         stat;
  logic              pop;
  logic              fifo_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vertex_count <= VC_RESET;
      cfg_r.degree_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VERTEX_COUNT: cfg_r.vertex_count <= cfg_wdata;
        CFG_DEGREE_LIMIT: cfg_r.degree_limit <= cfg_wdata[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  assign pop = out_valid && !out_stall;

  edb_seq #(
    .MAX_VERTICES(MAX_VERTICES),
    .ADDR_W      (ADDR_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .in_end_a (in_end_a),
    .in_end_b (in_end_b),
    .pop      (pop),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .res_push (res_push),
    .res_data (res_data),
    .stat     (stat)
  );

  edb_counter_mem #(
    .DEPTH (MAX_VERTICES),
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  edb_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_data),
    .pop      (pop),
    .out_valid(out_valid),
    .out_data (out_data),
    .full     (fifo_full)
  );

  assign out_vertex_index = out_data.vertex_index;
  assign out_degree       = out_data.degree;
  assign out_is_boundary  = out_data.is_boundary;
  assign out_status       = out_data.status;

  `EDB_ASSERT_IMPLY(a_no_accept_while_clearing, clk, rst_n, stat.clearing, in_stall)
  `EDB_ASSERT_IMPLY(a_no_accept_when_full, clk, rst_n, fifo_full && !pop, in_stall)
  `EDB_ASSERT_NEXT(a_accept_starts_work, clk, rst_n, in_valid && !in_stall, stat.busy)

endmodule
